// File: rtl/core/rbmf_pkg.sv
package rbmf_pkg;

  // ring of rows held in the row store
  localparam int unsigned RING_ROWS   = 16;
  localparam int unsigned RING_W      = 4;
  localparam int unsigned MAX_HEIGHT  = 4096;

  // field widths
  localparam int unsigned CH_W        = 8;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned LANES       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned IMG_W_W     = 11;
  localparam int unsigned IMG_H_W     = 13;
  localparam int unsigned KER_W       = 4;

  // window sum of up to 15x15 bytes, and the area k*k
  localparam int unsigned SUM_W       = 16;
  localparam int unsigned AREA_W      = 8;
  localparam int unsigned DIV_CNT_W   = 4;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2
  } reg_idx_t;

  // reset values
  localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [KER_W-1:0]   KERNEL_RST = 4'd3;

  // item kinds
  localparam logic MODE_PIXEL = 1'b0;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_PASS    = 7'b0000100,
    S_SUM     = 7'b0001000,
    S_SUMLAST = 7'b0010000,
    S_DIV     = 7'b0100000,
    S_OUT     = 7'b1000000
  } state_t;

endpackage

// File: rtl/core/rbmf_ifs.sv
interface rbmf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  modport source (output valid, mode, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, mode, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface rbmf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       was_averaged;
  logic       frame_last;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, was_averaged,
                  frame_last, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, was_averaged,
                  frame_last, output ready);
endinterface

interface rbmf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [12:0] wr_data;
  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// File: rtl/core/rgba_box_mean_filter.sv
// results: a pass-through result is taken from its row store read; an averaged one
//   needs one row store read per window pixel, then a 16-step restoring divide
//   that runs in parallel in each of the four channels
// items: one item at a time; an item that emits nothing goes back to idle after the check
// reset: positions and output valid cleared, registers to 640/480/3;
//   the row store and the window sums are not cleared
module rgba_box_mean_filter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_KERNEL = 15
) (
  input  logic         clk,
  input  logic         rst_n,
  rbmf_in_if.sink      in_ch,
  rbmf_out_if.source   out_ch,
  rbmf_cfg_if.sink     cfg_ch
);

  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW   = $clog2(rbmf_pkg::RING_ROWS * MAX_WIDTH);
  localparam int unsigned PW   = $clog2(MAX_WIDTH * rbmf_pkg::MAX_HEIGHT + 1);
  localparam int unsigned KMAX = (MAX_KERNEL - 1) | 1;
  localparam int unsigned DEPTH = rbmf_pkg::RING_ROWS * MAX_WIDTH;

  rbmf_pkg::state_t state_r;

  logic [rbmf_pkg::IMG_W_W-1:0] width_r;
  logic [rbmf_pkg::IMG_H_W-1:0] height_r;
  logic [rbmf_pkg::KER_W-1:0]   kernel_r;

  logic [PW-1:0]                in_pos_r;
  logic [XW-1:0]                in_x_r;
  logic [rbmf_pkg::RING_W-1:0]  in_row_r;
  logic [PW-1:0]                out_pos_r;
  logic [XW-1:0]                out_x_r;
  logic [rbmf_pkg::IMG_H_W-1:0] out_y_r;

  logic [rbmf_pkg::KER_W-1:0]   dy_r;
  logic [rbmf_pkg::KER_W-1:0]   dx_r;
  logic                         acc_en_r;
  logic [rbmf_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [rbmf_pkg::SUM_W-1:0]   sum_r [rbmf_pkg::LANES];
  logic [rbmf_pkg::CH_W-1:0]    rem_r [rbmf_pkg::LANES];
  logic [rbmf_pkg::SUM_W-1:0]   sum_div [rbmf_pkg::LANES];
  logic [rbmf_pkg::CH_W-1:0]    rem_div [rbmf_pkg::LANES];
  logic [rbmf_pkg::PIX_W-1:0]   pass_r;
  logic                         avg_r;

  logic                         out_valid_r;
  logic [rbmf_pkg::PIX_W-1:0]   out_px_r;
  logic                         out_avg_r;
  logic                         out_last_r;

  // row store
  logic [rbmf_pkg::PIX_W-1:0]   mem [DEPTH];
  logic [rbmf_pkg::PIX_W-1:0]   rd_data_r;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  logic [rbmf_pkg::PIX_W-1:0]   mem_wd;
  logic                         mem_re;
  logic [AW-1:0]                mem_ra;

  // effective configuration
  logic [WW-1:0]                eff_w;
  logic [rbmf_pkg::IMG_H_W-1:0] eff_h;
  logic [rbmf_pkg::KER_W-1:0]   k_odd;
  logic [rbmf_pkg::KER_W-1:0]   eff_k;
  logic [2:0]                   rad;
  logic [rbmf_pkg::AREA_W-1:0]  area;
  logic [PW-1:0]                total;
  logic [PW-1:0]                lag;

  always_comb begin
    if (width_r == '0) eff_w = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else eff_w = WW'(width_r);
    if (height_r == '0) eff_h = 13'd1;
    else if (32'(height_r) > rbmf_pkg::MAX_HEIGHT) eff_h = 13'(rbmf_pkg::MAX_HEIGHT);
    else eff_h = height_r;
    k_odd = kernel_r | 4'd1;
    if (k_odd < 4'd3) eff_k = 4'd3;
    else if (32'(k_odd) > KMAX) eff_k = 4'(KMAX);
    else eff_k = k_odd;
  end

  assign rad   = eff_k[3:1];
  assign area  = {4'd0, eff_k} * {4'd0, eff_k};
  assign total = PW'(eff_w) * PW'(eff_h);
  assign lag   = PW'(rad) * PW'(eff_w) + PW'(rad);

  // emission and border decisions for the pending result
  logic                       in_ok;
  logic                       emit;
  logic                       inner;
  logic [PW:0]                need;
  logic [rbmf_pkg::IMG_H_W:0] y_hi;
  logic [XW:0]                x_hi;
  logic                       win_last;

  assign in_ok  = (in_ch.mode == rbmf_pkg::MODE_PIXEL) && (in_pos_r < total);
  assign need   = {1'b0, out_pos_r} + {1'b0, lag};
  assign emit   = (out_pos_r < total) &&
                  ((in_pos_r >= total) || ({1'b0, in_pos_r} > need));
  assign y_hi   = {1'b0, out_y_r} + 14'(rad);
  assign x_hi   = {1'b0, out_x_r} + (XW+1)'(rad);
  assign inner  = (out_y_r >= 13'(rad)) && (y_hi < {1'b0, eff_h}) &&
                  ({1'b0, out_x_r} >= (XW+1)'(rad)) && (32'(x_hi) < 32'(eff_w));
  assign win_last = (dy_r == eff_k - 4'd1) && (dx_r == eff_k - 4'd1);

  // memory addresses
  logic [rbmf_pkg::RING_W-1:0] win_row;
  logic [XW-1:0]               win_col;

  assign win_row = 4'(out_y_r[3:0] - 4'(rad) + dy_r);
  assign win_col = XW'(out_x_r - XW'(rad) + XW'(dx_r));

  always_comb begin
    mem_we = (state_r == rbmf_pkg::S_IDLE) && in_ch.valid && in_ok;
    mem_wa = AW'(AW'(in_row_r) * AW'(MAX_WIDTH) + AW'(in_x_r));
    mem_wd = {in_ch.in_alpha, in_ch.in_blue, in_ch.in_green, in_ch.in_red};
    mem_re = 1'b0;
    mem_ra = AW'(AW'(win_row) * AW'(MAX_WIDTH) + AW'(win_col));
    if (state_r == rbmf_pkg::S_CHECK) begin
      mem_re = 1'b1;
      mem_ra = AW'(AW'(out_y_r[3:0]) * AW'(MAX_WIDTH) + AW'(out_x_r));
    end else if (state_r == rbmf_pkg::S_SUM) begin
      mem_re = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  // one restoring divide step per lane
  logic [rbmf_pkg::CH_W:0] trial [rbmf_pkg::LANES];

  always_comb begin
    for (int c = 0; c < rbmf_pkg::LANES; c++) begin
      trial[c] = {rem_r[c], sum_r[c][rbmf_pkg::SUM_W-1]};
      if (trial[c] >= {1'b0, area}) begin
        rem_div[c] = 8'(trial[c] - {1'b0, area});
        sum_div[c] = {sum_r[c][rbmf_pkg::SUM_W-2:0], 1'b1};
      end else begin
        rem_div[c] = trial[c][7:0];
        sum_div[c] = {sum_r[c][rbmf_pkg::SUM_W-2:0], 1'b0};
      end
    end
  end

  // register writes only when idle and no input is offered
  assign in_ch.ready  = (state_r == rbmf_pkg::S_IDLE);
  assign cfg_ch.ready = (state_r == rbmf_pkg::S_IDLE) && !in_ch.valid;

  // sequencer, positions and output register
  logic out_free;
  logic frame_end;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign frame_end = (out_pos_r + PW'(1)) == total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rbmf_pkg::S_IDLE;
      width_r     <= rbmf_pkg::WIDTH_RST;
      height_r    <= rbmf_pkg::HEIGHT_RST;
      kernel_r    <= rbmf_pkg::KERNEL_RST;
      in_pos_r    <= '0;
      in_x_r      <= '0;
      in_row_r    <= '0;
      out_pos_r   <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      acc_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_en_r <= (state_r == rbmf_pkg::S_SUM);
      if (out_ch.ready && state_r != rbmf_pkg::S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        rbmf_pkg::S_IDLE: begin
          if (in_ch.valid) begin
            if (in_ok) begin
              in_pos_r <= in_pos_r + PW'(1);
              if (32'(in_x_r) + 1 == 32'(eff_w)) begin
                in_x_r   <= '0;
                in_row_r <= in_row_r + 4'd1;
              end else begin
                in_x_r <= in_x_r + XW'(1);
              end
            end
            state_r <= rbmf_pkg::S_CHECK;
          end
        end
        rbmf_pkg::S_CHECK: begin
          dy_r <= '0;
          dx_r <= '0;
          avg_r <= inner;
          for (int c = 0; c < rbmf_pkg::LANES; c++) begin
            sum_r[c] <= '0;
            rem_r[c] <= '0;
          end
          if (!emit) state_r <= rbmf_pkg::S_IDLE;
          else if (inner) state_r <= rbmf_pkg::S_SUM;
          else state_r <= rbmf_pkg::S_PASS;
        end
        rbmf_pkg::S_PASS: begin
          pass_r  <= rd_data_r;
          state_r <= rbmf_pkg::S_OUT;
        end
        rbmf_pkg::S_SUM: begin
          if (dx_r == eff_k - 4'd1) begin
            dx_r <= '0;
            dy_r <= dy_r + 4'd1;
          end else begin
            dx_r <= dx_r + 4'd1;
          end
          if (win_last) state_r <= rbmf_pkg::S_SUMLAST;
        end
        rbmf_pkg::S_SUMLAST: begin
          div_cnt_r <= '0;
          state_r   <= rbmf_pkg::S_DIV;
        end
        rbmf_pkg::S_DIV: begin
          for (int c = 0; c < rbmf_pkg::LANES; c++) begin
            sum_r[c] <= sum_div[c];
            rem_r[c] <= rem_div[c];
          end
          div_cnt_r <= div_cnt_r + 4'd1;
          if (div_cnt_r == 4'(rbmf_pkg::SUM_W - 1)) state_r <= rbmf_pkg::S_OUT;
        end
        rbmf_pkg::S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_avg_r   <= avg_r;
            out_last_r  <= frame_end;
            if (avg_r) begin
              out_px_r <= {sum_r[3][7:0], sum_r[2][7:0], sum_r[1][7:0], sum_r[0][7:0]};
            end else begin
              out_px_r <= pass_r;
            end
            if (frame_end) begin
              in_pos_r  <= '0;
              in_x_r    <= '0;
              in_row_r  <= '0;
              out_pos_r <= '0;
              out_x_r   <= '0;
              out_y_r   <= '0;
            end else begin
              out_pos_r <= out_pos_r + PW'(1);
              if (32'(out_x_r) + 1 == 32'(eff_w)) begin
                out_x_r <= '0;
                out_y_r <= out_y_r + 13'd1;
              end else begin
                out_x_r <= out_x_r + XW'(1);
              end
            end
            state_r <= rbmf_pkg::S_IDLE;
          end
        end
        default: state_r <= rbmf_pkg::S_IDLE;
      endcase

      // window accumulation, one pixel behind the read
      if (acc_en_r && (state_r == rbmf_pkg::S_SUM || state_r == rbmf_pkg::S_SUMLAST)) begin
        for (int c = 0; c < rbmf_pkg::LANES; c++) begin
          sum_r[c] <= sum_r[c] + 16'(rd_data_r[8*c +: 8]);
        end
      end

      // a write to a defined register restarts the frame
      if (cfg_ch.valid && cfg_ch.ready) begin
        unique case (cfg_ch.reg_index)
          rbmf_pkg::REG_WIDTH:  width_r  <= cfg_ch.wr_data[10:0];
          rbmf_pkg::REG_HEIGHT: height_r <= cfg_ch.wr_data;
          rbmf_pkg::REG_KERNEL: kernel_r <= cfg_ch.wr_data[3:0];
          default: ;
        endcase
        if (cfg_ch.reg_index == rbmf_pkg::REG_WIDTH ||
            cfg_ch.reg_index == rbmf_pkg::REG_HEIGHT ||
            cfg_ch.reg_index == rbmf_pkg::REG_KERNEL) begin
          in_pos_r  <= '0;
          in_x_r    <= '0;
          in_row_r  <= '0;
          out_pos_r <= '0;
          out_x_r   <= '0;
          out_y_r   <= '0;
        end
      end
    end
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_red      = out_px_r[7:0];
  assign out_ch.out_green    = out_px_r[15:8];
  assign out_ch.out_blue     = out_px_r[23:16];
  assign out_ch.out_alpha    = out_px_r[31:24];
  assign out_ch.was_averaged = out_avg_r;
  assign out_ch.frame_last   = out_last_r;

endmodule

// File: sim/tb_rgba_box_mean_filter.sv
module tb_rgba_box_mean_filter;

  localparam logic       MODE_DRAIN = 1'b1;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         MAX_W      = 1024;
  localparam int         MAX_K      = 15;
  localparam int         SETTLE     = 300;
  localparam longint     CYCLE_CAP  = 4_000_000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       avg;
    logic       last;
  } pixel_res_t;

  logic clk;
  logic rst_n;

  rbmf_in_if  in_if ();
  rbmf_out_if out_if ();
  rbmf_cfg_if cfg_if ();

  rgba_box_mean_filter #(.MAX_WIDTH(MAX_W), .MAX_KERNEL(MAX_K)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // shadow of the filter state
  logic [31:0]  ring_mem [rbmf_pkg::RING_ROWS*MAX_W];
  int unsigned  fed_cnt;
  int unsigned  shown_cnt;
  logic [10:0]  w_reg;
  logic [12:0]  h_reg;
  logic [3:0]   k_reg;

  pixel_res_t   pending_q [$];
  int           mismatches;
  int           fed_items;
  longint       cycles;
  bit           idle_on;
  bit           hold_req;

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned eff_w();
    int unsigned v;
    v = w_reg;
    if (v < 1) v = 1;
    if (v > MAX_W) v = MAX_W;
    return v;
  endfunction

  function automatic int unsigned eff_h();
    int unsigned v;
    v = h_reg;
    if (v < 1) v = 1;
    if (v > rbmf_pkg::MAX_HEIGHT) v = rbmf_pkg::MAX_HEIGHT;
    return v;
  endfunction

  function automatic int unsigned eff_k();
    int unsigned v;
    v = k_reg | 4'd1;
    if (v < 3) v = 3;
    if (v > ((MAX_K - 1) | 1)) v = (MAX_K - 1) | 1;
    return v;
  endfunction

  function automatic int unsigned slot(int unsigned y, int unsigned x);
    return (y % rbmf_pkg::RING_ROWS) * MAX_W + (x % MAX_W);
  endfunction

  // one transaction into the box mean: returns 1 when it yields a pixel
  function automatic bit box_mean_step(logic m, logic [31:0] px, output pixel_res_t res);
    int unsigned w, h, k, r, total, lag, o, y, x, area;
    int unsigned sums [4];
    logic [31:0] v, outpx;
    w = eff_w();
    h = eff_h();
    k = eff_k();
    r = k / 2;
    total = w * h;
    lag = r * w + r;
    res = '0;
    if (m == rbmf_pkg::MODE_PIXEL && fed_cnt < total) begin
      ring_mem[slot(fed_cnt / w, fed_cnt % w)] = px;
      fed_cnt++;
    end
    o = shown_cnt;
    if (o >= total) return 1'b0;
    if (!(fed_cnt >= total || fed_cnt > o + lag)) return 1'b0;
    y = o / w;
    x = o % w;
    if (y >= r && y + r < h && x >= r && x + r < w) begin
      area = k * k;
      for (int c = 0; c < 4; c++) sums[c] = 0;
      for (int dy = 0; dy < k; dy++)
        for (int dx = 0; dx < k; dx++) begin
          v = ring_mem[slot(y - r + dy, x - r + dx)];
          for (int c = 0; c < 4; c++) sums[c] += v[8*c +: 8];
        end
      for (int c = 0; c < 4; c++) outpx[8*c +: 8] = 8'(sums[c] / area);
      res.avg = 1'b1;
    end else begin
      outpx = ring_mem[slot(y, x)];
    end
    res.red   = outpx[7:0];
    res.green = outpx[15:8];
    res.blue  = outpx[23:16];
    res.alpha = outpx[31:24];
    res.last  = (o + 1 == total);
    if (o + 1 == total) begin
      fed_cnt   = 0;
      shown_cnt = 0;
    end else begin
      shown_cnt = o + 1;
    end
    return 1'b1;
  endfunction

  function automatic bit frame_waiting();
    return fed_cnt == eff_w() * eff_h();
  endfunction

  // send one item, valid left high after the transaction
  task automatic send_item(logic m, logic [31:0] px);
    int gap;
    pixel_res_t res;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.mode     <= m;
    in_if.in_red   <= px[7:0];
    in_if.in_green <= px[15:8];
    in_if.in_blue  <= px[23:16];
    in_if.in_alpha <= px[31:24];
    do @(posedge clk); while (!in_if.ready);
    fed_items++;
    if (box_mean_step(m, px, res)) pending_q.push_back(res);
  endtask

  // wait until the block is quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [12:0] data);
    cfg_if.valid     <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.wr_data   <= data;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      rbmf_pkg::REG_WIDTH:  w_reg = data[10:0];
      rbmf_pkg::REG_HEIGHT: h_reg = data[12:0];
      rbmf_pkg::REG_KERNEL: k_reg = data[3:0];
      default:    ;
    endcase
    if (idx != REG_UNUSED) begin
      fed_cnt   = 0;
      shown_cnt = 0;
    end
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_pixel(bit harsh);
    logic [31:0] px;
    px = $urandom;
    if (harsh)
      for (int c = 0; c < 4; c++)
        case ($urandom_range(0, 2))
          0: px[8*c +: 8] = 8'h00;
          1: px[8*c +: 8] = 8'hFF;
          default: ;
        endcase
    return px;
  endfunction

  // configure, feed npix pixels, then drain when the frame is complete
  task automatic play_frame(int w, int h, int k, int npix, bit harsh, bit noise);
    settle();
    cfg_write(rbmf_pkg::REG_WIDTH,  {2'($urandom), 11'(w)});
    cfg_write(rbmf_pkg::REG_HEIGHT, 13'(h));
    cfg_write(rbmf_pkg::REG_KERNEL, {9'($urandom), 4'(k)});
    for (int i = 0; i < npix; i++) begin
      if (noise && $urandom_range(0, 19) == 0) send_item(MODE_DRAIN, $urandom);
      send_item(rbmf_pkg::MODE_PIXEL, pick_pixel(harsh));
    end
    while (frame_waiting())
      send_item(($urandom_range(0, 4) == 0) ? rbmf_pkg::MODE_PIXEL : MODE_DRAIN, $urandom);
  endtask

  // result checker
  always @(posedge clk) begin
    pixel_res_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.red   = out_if.out_red;
      got.green = out_if.out_green;
      got.blue  = out_if.out_blue;
      got.alpha = out_if.out_alpha;
      got.avg   = out_if.was_averaged;
      got.last  = out_if.frame_last;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // result receiver
  initial begin
    int gap;
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // defaults are 640 x 480; a few pixels and early drains give nothing
  task automatic test_defaults();
    send_item(MODE_DRAIN, $urandom);
    for (int i = 0; i < 6; i++) send_item(rbmf_pkg::MODE_PIXEL, pick_pixel(1));
    send_item(MODE_DRAIN, $urandom);
    settle();
    cfg_write(REG_UNUSED, 13'h1FFF);
    send_item(rbmf_pkg::MODE_PIXEL, pick_pixel(1));
  endtask

  task automatic test_extremes();
    play_frame(5, 5, 3, 25, 1, 0);
    play_frame(4, 4, 3, 16, 1, 1);
  endtask

  // image smaller than the window passes through
  task automatic test_small_image();
    play_frame(2, 2, 5, 4, 0, 0);
    play_frame(1, 1, 15, 1, 0, 0);
  endtask

  // even and out-of-range kernel codes
  task automatic test_kernel_codes();
    play_frame(5, 4, 0, 20, 0, 0);
    play_frame(4, 5, 1, 20, 0, 0);
    play_frame(6, 4, 2, 24, 0, 0);
    play_frame(7, 6, 4, 42, 0, 0);
    play_frame(15, 15, 14, 225, 1, 0);
  endtask

  task automatic test_size_extremes();
    play_frame(0, 3, 3, 3, 0, 0);
    play_frame(6, 0, 3, 6, 0, 0);
    play_frame(2047, 1, 3, 20, 0, 0);
    play_frame(1024, 2, 3, 20, 0, 0);
    play_frame(1, 8191, 3, 40, 0, 0);
    play_frame(1, 4096, 3, 30, 0, 0);
  endtask

  // long receiver hold-off while pixels keep coming
  task automatic test_backpressure();
    settle();
    hold_req = 1'b1;
    play_frame(8, 8, 3, 64, 0, 0);
  endtask

  task automatic test_random();
    int w, h, k, npix, start;
    start = fed_items;
    while (fed_items - start < 100) begin
      idle_on = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 20) : $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 5);
      npix = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * h) : w * h;
      play_frame(w, h, k, npix, $urandom_range(0, 1), $urandom_range(0, 3) == 0);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.mode       <= rbmf_pkg::MODE_PIXEL;
    in_if.in_red     <= '0;
    in_if.in_green   <= '0;
    in_if.in_blue    <= '0;
    in_if.in_alpha   <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.reg_index <= rbmf_pkg::REG_WIDTH;
    cfg_if.wr_data   <= '0;
    rst_n            <= 1'b0;
    cycles     = 0;
    mismatches = 0;
    fed_items  = 0;
    idle_on    = 1'b1;
    hold_req   = 1'b0;
    fed_cnt    = 0;
    shown_cnt  = 0;
    w_reg      = rbmf_pkg::WIDTH_RST;
    h_reg      = rbmf_pkg::HEIGHT_RST;
    k_reg      = rbmf_pkg::KERNEL_RST;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults();
    test_extremes();
    test_small_image();
    test_kernel_codes();
    test_size_extremes();
    test_backpressure();
    test_random();

    settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
